// File: hw/rtl/itp_pkg.sv
// Shared types, character codes and a helper function for the infix-to-postfix converter.
package itp_pkg;

  // Item kinds assigned by the front end.
  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_OPEN    = 3'd1;
  localparam logic [2:0] KIND_CLOSE   = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;

  // ASCII codes of the operators and brackets.
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Status codes carried with each result.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_NO_OPEN   = 2'd2;
  localparam logic [1:0] STAT_OPEN_LEFT = 2'd3;

  // One classified item passed from the front end to the back end.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sym;
  } q_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic       has_sym;
    logic [7:0] sym;
  } res_t;

  // Operator precedence; zero for anything that is not an operator.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if (c == CH_STAR || c == CH_SLASH) begin
      p = 2'd2;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/itp_front.sv
// Front end: accepts input items, classifies each character and queues it for the back end.
module itp_front
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  output logic       q_valid,
  output q_item_t    q_item,
  input  logic       q_pop
);

  q_item_t    ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  q_item_t    cls;
  logic       push;

  // Classify the incoming character.
  always_comb begin
    cls.sym = in_tdata;
    if (in_tuser) begin
      cls.kind = KIND_END;
    end else if (in_tdata == CH_OPEN) begin
      cls.kind = KIND_OPEN;
    end else if (in_tdata == CH_CLOSE) begin
      cls.kind = KIND_CLOSE;
    end else if (prec_of(in_tdata) != 2'd0) begin
      cls.kind = KIND_OPER;
    end else begin
      cls.kind = KIND_OPERAND;
    end
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = ent_r[rd_ptr_r];

  // Two-entry queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop && q_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, (q_pop && q_valid)};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/itp_back.sv
// Back end: runs the operator stack and produces result items through an output register.
module itp_back
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    out_tvalid,
  input  logic    out_tready,
  output res_t    out_res
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic          state_r;
  q_item_t       cur_r;
  logic [1:0]    st_acc_r;
  logic [CW-1:0] cnt_r;
  logic [7:0]    top_r;
  logic          top_mem_r;
  logic [7:0]    rd_q_r;
  logic          pend_vld_r;
  logic [7:0]    pend_sym_r;
  logic          out_valid_r;
  res_t          out_res_r;
  logic [7:0]    mem [STACK_DEPTH];

  logic [7:0]    top;
  logic          nonempty;
  logic          full;
  logic [1:0]    pt;
  logic [1:0]    pc;
  logic          can_emit;
  logic          want_emit;
  res_t          res;
  logic          want_push;
  logic          want_pop;
  logic          want_done;
  logic          want_pend_ld;
  logic          want_pend_clr;
  logic          want_open_err;
  logic          go;
  logic          exec;
  logic          emit;
  logic          push;
  logic          pop;
  logic [CW-1:0] rd_cnt;

  assign top      = top_mem_r ? rd_q_r : top_r;
  assign nonempty = (cnt_r != '0);
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign pt       = prec_of(top);
  assign pc       = prec_of(cur_r.sym);
  assign can_emit = !out_valid_r || out_tready;
  assign rd_cnt   = cnt_r - CW'(2);

  // Decide what the current item does this cycle.
  always_comb begin
    want_emit     = 1'b0;
    res           = '0;
    want_push     = 1'b0;
    want_pop      = 1'b0;
    want_done     = 1'b0;
    want_pend_ld  = 1'b0;
    want_pend_clr = 1'b0;
    want_open_err = 1'b0;
    unique case (cur_r.kind)
      KIND_OPEN: begin
        want_done = 1'b1;
        if (full) begin
          want_emit  = 1'b1;
          res.last   = 1'b1;
          res.status = STAT_OVERFLOW;
        end else begin
          want_push = 1'b1;
        end
      end
      KIND_OPER: begin
        if (nonempty && top != CH_OPEN &&
            (pt > pc || (pt == pc && cur_r.sym != CH_CARET))) begin
          // Pop the top; a held popped operator goes out first.
          want_pop     = 1'b1;
          want_pend_ld = 1'b1;
          want_emit    = pend_vld_r;
          res.sym      = pend_sym_r;
          res.has_sym  = 1'b1;
        end else if (pend_vld_r) begin
          // Popping freed a slot, so the push succeeds.
          want_emit     = 1'b1;
          res.sym       = pend_sym_r;
          res.has_sym   = 1'b1;
          res.last      = 1'b1;
          want_push     = 1'b1;
          want_pend_clr = 1'b1;
          want_done     = 1'b1;
        end else if (full) begin
          want_emit  = 1'b1;
          res.last   = 1'b1;
          res.status = STAT_OVERFLOW;
          want_done  = 1'b1;
        end else begin
          want_push = 1'b1;
          want_done = 1'b1;
        end
      end
      KIND_CLOSE: begin
        if (!nonempty) begin
          want_emit = 1'b1;
          if (pend_vld_r) begin
            res.sym       = pend_sym_r;
            res.has_sym   = 1'b1;
            want_pend_clr = 1'b1;
          end else begin
            res.last   = 1'b1;
            res.status = STAT_NO_OPEN;
            want_done  = 1'b1;
          end
        end else if (top == CH_OPEN) begin
          // Matching bracket: discard it and close the item.
          want_pop      = 1'b1;
          want_emit     = pend_vld_r;
          res.sym       = pend_sym_r;
          res.has_sym   = 1'b1;
          res.last      = 1'b1;
          want_pend_clr = 1'b1;
          want_done     = 1'b1;
        end else begin
          want_pop     = 1'b1;
          want_pend_ld = 1'b1;
          want_emit    = pend_vld_r;
          res.sym      = pend_sym_r;
          res.has_sym  = 1'b1;
        end
      end
      KIND_END: begin
        if (nonempty) begin
          want_pop = 1'b1;
          if (top == CH_OPEN) begin
            want_open_err = 1'b1;
          end else begin
            want_emit   = 1'b1;
            res.sym     = top;
            res.has_sym = 1'b1;
          end
        end else begin
          want_emit  = 1'b1;
          res.last   = 1'b1;
          res.status = st_acc_r;
          want_done  = 1'b1;
        end
      end
      default: begin
        // Operand goes straight out.
        want_emit   = 1'b1;
        res.sym     = cur_r.sym;
        res.has_sym = 1'b1;
        res.last    = 1'b1;
        want_done   = 1'b1;
      end
    endcase
  end

  assign exec  = (state_r == ST_EXEC);
  assign go    = exec && (!want_emit || can_emit);
  assign emit  = go && want_emit;
  assign push  = go && want_push;
  assign pop   = go && want_pop;
  assign q_pop = (state_r == ST_IDLE) && q_valid;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      top_mem_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        state_r <= ST_EXEC;
      end else if (go && want_done) begin
        state_r <= ST_IDLE;
      end
      if (pop) begin
        cnt_r     <= cnt_r - CW'(1);
        top_mem_r <= 1'b1;
      end else if (push) begin
        cnt_r     <= cnt_r + CW'(1);
        top_mem_r <= 1'b0;
      end
      if (go && want_pend_ld) begin
        pend_vld_r <= 1'b1;
      end else if (go && want_pend_clr) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r    <= q_item;
      st_acc_r <= STAT_OK;
    end else if (go && want_open_err) begin
      st_acc_r <= STAT_OPEN_LEFT;
    end
    if (push) begin
      top_r <= cur_r.sym;
    end
    if (go && want_pend_ld) begin
      pend_sym_r <= top;
    end
    if (emit) begin
      out_res_r <= res;
    end
  end

  // Stack memory: the entry below the top is read when the top is popped.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[cnt_r[AW-1:0]] <= cur_r.sym;
    end
    if (pop && cnt_r >= CW'(2)) begin
      rd_q_r <= mem[rd_cnt[AW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// Top level of the infix-to-postfix converter: front end, queue and stack back end.
//
//  channel | direction | tdata                          | tuser      | tlast
//  in_     | slave     | [7:0] symbol                   | mode       | -
//  out_    | master    | [7:0] out_symbol, [9:8] status | has_symbol | last
//
// Every item leaves the queue while the back end is idle and is then executed there; the
// back end takes the next item only once the current one is done. Stack entries are
// popped one at a time, set by the single-port stack memory and its registered read; an
// operator then pushes itself, an end item emits its marker, and a ')' that pops operators
// without meeting '(' emits the last operator and then its status item.
// Reset empties the stack and the queue at once; a stalled output register holds the back
// end while the two-entry queue keeps taking items until it is full.
module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_symbol, [9:8] status
  output logic        out_tuser,  // [0] has_symbol
  output logic        out_tlast
);

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;
  res_t    res;

  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Pack the result onto the stream.
  assign out_tdata = {6'b0, res.status, res.sym};
  assign out_tuser = res.has_sym;
  assign out_tlast = res.last;

endmodule

// File: hw/rtl/itp_checker.sv
// Port-level checker for the infix-to-postfix converter, bound to the top level.
module itp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // An emitted character always comes with ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[9:8] == 2'd0)
    else $error("character result with error status");

  // A result without a character closes its item and carries a zero symbol.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("marker result malformed");

  // Padding bits stay zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:10] == 6'd0)
    else $error("padding bits set");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/infix_to_postfix_converter_unit_tb.sv
// Self-checking testbench for the infix-to-postfix converter: directed table, then random runs.
module infix_to_postfix_converter_unit_tb
  import itp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 32;
  localparam int RANDOM_ITEMS = 120;

  // Values of the mode field.
  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  // One stimulus item, with an optional hand-written expected result.
  typedef struct packed {
    logic       mode;
    logic [7:0] sym;
    logic       typed;
    res_t       want;
  } row_t;

  localparam res_t NO_RES = '0;

  // Directed part. Typed rows carry their single expected result.
  localparam int N_ROWS = 26;
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{MODE_END,  8'h00,    1'b1, '{STAT_OK,      1'b1, 1'b0, 8'h00}},
    '{MODE_CHAR, CH_CLOSE, 1'b1, '{STAT_NO_OPEN, 1'b1, 1'b0, 8'h00}},
    '{MODE_CHAR, 8'h00,    1'b1, '{STAT_OK,      1'b1, 1'b1, 8'h00}},
    '{MODE_CHAR, 8'hFF,    1'b1, '{STAT_OK,      1'b1, 1'b1, 8'hFF}},
    '{MODE_CHAR, "a",      1'b0, NO_RES},
    '{MODE_CHAR, CH_PLUS,  1'b0, NO_RES},
    '{MODE_CHAR, "b",      1'b0, NO_RES},
    '{MODE_CHAR, CH_STAR,  1'b0, NO_RES},
    '{MODE_CHAR, "c",      1'b0, NO_RES},
    '{MODE_CHAR, CH_CARET, 1'b0, NO_RES},
    '{MODE_CHAR, "d",      1'b0, NO_RES},
    '{MODE_CHAR, CH_CARET, 1'b0, NO_RES},
    '{MODE_CHAR, "e",      1'b0, NO_RES},
    '{MODE_CHAR, CH_MINUS, 1'b0, NO_RES},
    '{MODE_CHAR, "f",      1'b0, NO_RES},
    '{MODE_CHAR, CH_SLASH, 1'b0, NO_RES},
    '{MODE_CHAR, "g",      1'b0, NO_RES},
    '{MODE_END,  8'hA5,    1'b0, NO_RES},
    '{MODE_CHAR, CH_OPEN,  1'b0, NO_RES},
    '{MODE_CHAR, CH_OPEN,  1'b0, NO_RES},
    '{MODE_CHAR, "x",      1'b0, NO_RES},
    '{MODE_CHAR, CH_CLOSE, 1'b0, NO_RES},
    '{MODE_END,  8'h00,    1'b0, NO_RES},
    '{MODE_CHAR, CH_OPEN,  1'b0, NO_RES},
    '{MODE_CHAR, CH_CLOSE, 1'b0, NO_RES},
    '{MODE_END,  8'hFF,    1'b1, '{STAT_OK,      1'b1, 1'b0, 8'h00}}
  };

  localparam logic [7:0] OPERATORS [5] = '{CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  infix_to_postfix_converter_unit #(.STACK_DEPTH(STACK_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predictor state: the operator stack as the block should hold it.
  logic [7:0] op_stack [STACK_DEPTH];
  int         op_depth;
  res_t       postfix_q [$];   // expected results, oldest first
  row_t       infix_q [$];     // items waiting to be offered
  int         mismatches;
  int         items_sent;
  bit         hold_req;
  res_t       mon_want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("infix_to_postfix_converter_unit_tb: done, errors");
    $finish;
  end

  function automatic int rank(logic [7:0] c);
    case (c)
      CH_CARET:           return 3;
      CH_STAR, CH_SLASH:  return 2;
      CH_PLUS, CH_MINUS:  return 1;
      default:            return 0;
    endcase
  endfunction

  function automatic bit is_special(logic [7:0] c);
    return rank(c) != 0 || c == CH_OPEN || c == CH_CLOSE;
  endfunction

  function automatic void emit(logic [7:0] s, logic has, logic last, logic [1:0] st);
    res_t r;
    r.sym     = s;
    r.has_sym = has;
    r.last    = last;
    r.status  = st;
    postfix_q.push_back(r);
  endfunction

  // Closes the results of one item: an error adds a status result,
  // otherwise the final emitted symbol (if any) is marked last.
  function automatic void close_item(int base, logic [1:0] st);
    if (st != STAT_OK) begin
      emit(8'h00, 1'b0, 1'b1, st);
    end else if (postfix_q.size() > base) begin
      postfix_q[postfix_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic logic [1:0] push_op(logic [7:0] c);
    if (op_depth >= STACK_DEPTH) begin
      return STAT_OVERFLOW;
    end
    op_stack[op_depth] = c;
    op_depth++;
    return STAT_OK;
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic void convert_symbol(row_t it);
    int         base;
    logic [7:0] t;
    logic [1:0] st;
    bit         found;
    base  = postfix_q.size();
    st    = STAT_OK;
    found = 1'b0;
    if (it.mode == MODE_END) begin
      // Flush: brackets are dropped but remembered in the marker's status.
      while (op_depth > 0) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == CH_OPEN) begin
          st = STAT_OPEN_LEFT;
        end else begin
          emit(t, 1'b1, 1'b0, STAT_OK);
        end
      end
      emit(8'h00, 1'b0, 1'b1, st);
    end else if (it.sym == CH_OPEN) begin
      close_item(base, push_op(it.sym));
    end else if (it.sym == CH_CLOSE) begin
      while (op_depth > 0 && !found) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == CH_OPEN) begin
          found = 1'b1;
        end else begin
          emit(t, 1'b1, 1'b0, STAT_OK);
        end
      end
      close_item(base, found ? STAT_OK : STAT_NO_OPEN);
    end else if (rank(it.sym) != 0) begin
      // Pop while the top binds tighter, or equally for left-associative operators.
      while (op_depth > 0 && op_stack[op_depth - 1] != CH_OPEN &&
             (rank(op_stack[op_depth - 1]) > rank(it.sym) ||
              (rank(op_stack[op_depth - 1]) == rank(it.sym) && it.sym != CH_CARET))) begin
        op_depth--;
        emit(op_stack[op_depth], 1'b1, 1'b0, STAT_OK);
      end
      close_item(base, push_op(it.sym));
    end else begin
      emit(it.sym, 1'b1, 1'b1, STAT_OK);
    end
    // A typed row replaces the predicted result with the one written in the table.
    if (it.typed) begin
      while (postfix_q.size() > base) begin
        void'(postfix_q.pop_back());
      end
      postfix_q.push_back(it.want);
    end
  endfunction

  // Stimulus builders.
  function automatic void add_item(logic m, logic [7:0] s);
    row_t r;
    r.mode  = m;
    r.sym   = s;
    r.typed = 1'b0;
    r.want  = NO_RES;
    infix_q.push_back(r);
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] s;
    do begin
      s = 8'($urandom_range(0, 255));
    end while (is_special(s));
    return s;
  endfunction

  // A balanced expression with random operands, operators and brackets.
  function automatic void gen_expr();
    int terms;
    int opens;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int i = 0; i < terms; i++) begin
      while (opens < 4 && $urandom_range(0, 3) == 0) begin
        add_item(MODE_CHAR, CH_OPEN);
        opens++;
      end
      add_item(MODE_CHAR, rand_operand());
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        add_item(MODE_CHAR, CH_CLOSE);
        opens--;
      end
      if (i < terms - 1) begin
        add_item(MODE_CHAR, OPERATORS[$urandom_range(0, 4)]);
      end
    end
    repeat (opens) add_item(MODE_CHAR, CH_CLOSE);
    add_item(MODE_END, 8'($urandom_range(0, 255)));
  endfunction

  // Fills the stack to one below its depth or past it, then flushes it.
  function automatic void gen_deep(bit carets_only);
    int n;
    n = carets_only ? STACK_DEPTH + 1 : $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 3);
    for (int i = 0; i < n; i++) begin
      add_item(MODE_CHAR, (carets_only || $urandom_range(0, 1)) ? CH_CARET : CH_OPEN);
    end
    add_item(MODE_CHAR, rand_operand());
    add_item(MODE_END, 8'h00);
  endfunction

  // Short malformed runs of brackets, operators and operands.
  function automatic void gen_broken();
    int n;
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       add_item(MODE_CHAR, CH_OPEN);
        1:       add_item(MODE_CHAR, CH_CLOSE);
        2:       add_item(MODE_CHAR, OPERATORS[$urandom_range(0, 4)]);
        default: add_item(MODE_CHAR, rand_operand());
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      add_item(MODE_END, 8'h00);
    end
  endfunction

  function automatic void gen_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endfunction

  // Offers one item from the falling edge and waits for it to be taken.
  task automatic offer(row_t it);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= it.sym;
    do begin
      @(posedge clk);
    end while (!in_tready);
    convert_symbol(it);
    items_sent++;
  endtask

  task automatic idle(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Sends every waiting item in bursts of random length.
  task automatic send_pending();
    int burst;
    burst = $urandom_range(1, 12);
    while (infix_q.size() > 0) begin
      offer(infix_q.pop_front());
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          idle($urandom_range(1, 6));
        end
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic drain();
    idle(1);
    while (postfix_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (postfix_q.size() == 0) begin
        flag_error($sformatf("unexpected result: sym %h has %b last %b status %0d",
                             out_tdata[7:0], out_tuser, out_tlast, out_tdata[9:8]));
      end else begin
        mon_want = postfix_q.pop_front();
        if (out_tdata[7:0] !== mon_want.sym || out_tdata[9:8] !== mon_want.status ||
            out_tuser !== mon_want.has_sym || out_tlast !== mon_want.last) begin
          flag_error($sformatf(
            "mismatch: exp sym %h has %b last %b status %0d, got sym %h has %b last %b status %0d",
            mon_want.sym, mon_want.has_sym, mon_want.last, mon_want.status,
            out_tdata[7:0], out_tuser, out_tlast, out_tdata[9:8]));
        end
      end
    end
  end

  // Receiver: phases of full, random and sparse readiness, plus one long hold.
  initial begin
    int phase_left;
    int style;
    out_tready = 1'b0;
    phase_left = 0;
    style      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      if (phase_left == 0) begin
        style      = $urandom_range(0, 2);
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      case (style)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Main stimulus sequence.
  initial begin
    int base_sent;
    int kind;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tuser   = MODE_CHAR;
    hold_req   = 1'b0;
    op_depth   = 0;
    mismatches = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) infix_q.push_back(DIR_ROWS[i]);
    send_pending();
    drain();

    // Hold the output while whole expressions keep arriving, then overflow the stack.
    base_sent = items_sent;
    hold_req  = 1'b1;
    repeat (4) gen_expr();
    gen_deep(1'b1);
    send_pending();

    while (items_sent - base_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 14);
      if (kind < 10) begin
        gen_expr();
      end else if (kind < 12) begin
        gen_broken();
      end else if (kind < 14) begin
        gen_noise();
      end else begin
        gen_deep(1'b0);
      end
      send_pending();
      if ($urandom_range(0, 7) == 0) begin
        drain();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("infix_to_postfix_converter_unit_tb: done, clean");
    end else begin
      $display("infix_to_postfix_converter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
